/* rtl/slr_pkg.sv */
`timescale 1ns / 1ps
// slr_pkg: shared types and fixed-point constants for the spot light radiance pipeline.
// Depends on nothing; used by spot_light_radiance and tb_spot_light_radiance.
package slr_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_RADIANCE   = 3'd0,
    CFG_LIGHT_X    = 3'd1,
    CFG_LIGHT_Y    = 3'd2,
    CFG_LIGHT_Z    = 3'd3,
    CFG_AIM_VECTOR = 3'd4,
    CFG_AIM_MODE   = 3'd5,
    CFG_COS_INNER  = 3'd6,
    CFG_COS_OUTER  = 3'd7
  } cfg_idx_e;

  // |d| stays below 2^20 once far hits are cut, the axis below 2^21 after scaling
  localparam int unsigned DMAG_W    = 20;
  localparam int unsigned AMAG_W    = 21;
  localparam int unsigned DIST_W    = 42;
  localparam int unsigned ASUM_W    = 44;
  localparam int unsigned SQRT_IN_W = 60;
  localparam int unsigned LEN_W     = 30;
  localparam int unsigned DIR_Q_W   = 15;
  localparam int unsigned DIR_SHIFT = 22;
  localparam int unsigned T_Q_W     = 14;

  localparam logic [14:0]        ONE_Q14  = 15'd16384;
  localparam logic signed [15:0] COS_ONE  = 16'sd16384;
  localparam logic [15:0]        DEN_MIN  = 16'd16;
  localparam logic [41:0]        DIST_MIN = 42'd7;

  // sideband through the square root
  typedef struct packed {
    logic                     dead;
    logic [DIST_W-1:0]        dist2;
    logic [2:0]               dsgn;
    logic [2:0]               asgn;
    logic [2:0][DMAG_W-1:0]   dmag;
    logic [2:0][AMAG_W-1:0]   amag;
  } norm_side_t;

  // sideband through the direction dividers
  typedef struct packed {
    logic              dead;
    logic [DIST_W-1:0] dist2;
    logic [2:0]        dsgn;
    logic [2:0]        asgn;
  } dir_side_t;

  // sideband through the cone divider
  typedef struct packed {
    logic              dead;
    logic              sat_t;
    logic [DIST_W-1:0] dist2;
  } cone_side_t;

  // sideband through the color dividers
  typedef struct packed {
    logic       dead;
    logic [2:0] sat;
  } col_side_t;

endpackage

/* rtl/slr_isqrt.sv */
`timescale 1ns / 1ps
// slr_isqrt: pipelined integer square root, two root bits per stage.
// Standalone; carries a sideband word along with each beat.
module slr_isqrt #(
  parameter int unsigned IN_W   = 60,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [IN_W-1:0]     arg_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);
  localparam int unsigned R_W   = IN_W / 2;
  localparam int unsigned REM_W = R_W + 3;
  localparam int unsigned NST   = (R_W + 1) / 2;

  logic              vld_q  [NST];
  logic [REM_W-1:0]  rem_q  [NST];
  logic [R_W-1:0]    root_q [NST];
  logic [IN_W-1:0]   arg_q  [NST];
  logic [SIDE_W-1:0] side_q [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    localparam bit HAS2 = (2 * s + 2 <= R_W);
    logic              vld_in;
    logic [REM_W-1:0]  rem_in, rem_a, rem_d;
    logic [R_W-1:0]    root_in, root_a, root_d;
    logic [IN_W-1:0]   arg_in, arg_a, arg_d;
    logic [SIDE_W-1:0] side_in;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign arg_in  = arg_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign arg_in  = arg_q[s-1];
      assign side_in = side_q[s-1];
    end

    // one or two restoring root steps
    always_comb begin
      rem_a = {rem_in[REM_W-3:0], arg_in[IN_W-1 -: 2]};
      arg_a = arg_in << 2;
      if (rem_a >= REM_W'({root_in, 2'b01})) begin
        rem_a  = rem_a - REM_W'({root_in, 2'b01});
        root_a = {root_in[R_W-2:0], 1'b1};
      end else begin
        root_a = {root_in[R_W-2:0], 1'b0};
      end
      rem_d  = rem_a;
      root_d = root_a;
      arg_d  = arg_a;
      if (HAS2) begin
        rem_d = {rem_a[REM_W-3:0], arg_a[IN_W-1 -: 2]};
        arg_d = arg_a << 2;
        if (rem_d >= REM_W'({root_a, 2'b01})) begin
          rem_d  = rem_d - REM_W'({root_a, 2'b01});
          root_d = {root_a[R_W-2:0], 1'b1};
        end else begin
          root_d = {root_a[R_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      root_q[s] <= root_d;
      arg_q[s]  <= arg_d;
      side_q[s] <= side_in;
    end
  end

  assign valid_o = vld_q[NST-1];
  assign root_o  = root_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule

/* rtl/slr_div.sv */
`timescale 1ns / 1ps
// slr_div: pipelined unsigned restoring divider, two quotient bits per stage.
// Standalone; expects num_i < den_i * 2^Q_W. Carries a sideband word per beat.
module slr_div #(
  parameter int unsigned DEN_W  = 16,
  parameter int unsigned Q_W    = 14,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [DEN_W+Q_W-1:0]   num_i,
  input  logic [DEN_W-1:0]       den_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   valid_o,
  output logic [Q_W-1:0]         quo_o,
  output logic [SIDE_W-1:0]      side_o
);
  localparam int unsigned W   = DEN_W + Q_W;
  localparam int unsigned NST = (Q_W + 1) / 2;

  logic              vld_q  [NST];
  logic [W-1:0]      rem_q  [NST];
  logic [Q_W-1:0]    quo_q  [NST];
  logic [DEN_W-1:0]  den_q  [NST];
  logic [SIDE_W-1:0] side_q [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    localparam int B0   = int'(Q_W) - 1 - 2 * s;
    localparam bit HAS2 = (B0 >= 1);
    localparam int B1   = HAS2 ? B0 - 1 : 0;
    logic              vld_in;
    logic [W-1:0]      rem_in, rem_a, rem_d;
    logic [Q_W-1:0]    quo_in, quo_d;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    // compare and subtract the shifted divisor
    always_comb begin
      rem_a = rem_in;
      quo_d = quo_in;
      if (rem_in >= (W'(den_in) << B0)) begin
        rem_a     = rem_in - (W'(den_in) << B0);
        quo_d[B0] = 1'b1;
      end
      rem_d = rem_a;
      if (HAS2) begin
        if (rem_a >= (W'(den_in) << B1)) begin
          rem_d     = rem_a - (W'(den_in) << B1);
          quo_d[B1] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      quo_q[s]  <= quo_d;
      den_q[s]  <= den_in;
      side_q[s] <= side_in;
    end
  end

  assign valid_o = vld_q[NST-1];
  assign quo_o   = quo_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule

/* rtl/spot_light_radiance.sv */
`timescale 1ns / 1ps
// spot_light_radiance: spot light cone and inverse-square radiance at one hit point.
// Throughput one hit per cycle, busy is held low. Depth is set by the 15-stage square
// root, the direction, cone and color dividers. done_o pulses one cycle per result.
// Reset clears all valid bits and loads the register defaults (cos_inner = 1.0).
module spot_light_radiance #(
  parameter int unsigned COORD_WIDTH = 20,
  parameter int unsigned COLOR_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [((3*COLOR_WIDTH > 3*COORD_WIDTH) ? 3*COLOR_WIDTH : 3*COORD_WIDTH)-1:0]
                                        cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] hit_x_i,
  input  logic signed [COORD_WIDTH-1:0] hit_y_i,
  input  logic signed [COORD_WIDTH-1:0] hit_z_i,
  output logic                          done_o,
  output logic [COLOR_WIDTH-1:0]        red_o,
  output logic [COLOR_WIDTH-1:0]        green_o,
  output logic [COLOR_WIDTH-1:0]        blue_o,
  output logic                          saturated_o
);
  localparam int unsigned CW       = COORD_WIDTH;
  localparam int unsigned AW       = COORD_WIDTH + 1;
  localparam int unsigned DIR_N_W  = slr_pkg::LEN_W + slr_pkg::DIR_Q_W;
  localparam int unsigned NUMER_W  = COLOR_WIDTH + 17;
  localparam int unsigned CDIV_W   = slr_pkg::DIST_W + COLOR_WIDTH;

  // ---------------------------------------------------------------- config
  logic [3*COLOR_WIDTH-1:0]  rad_q;
  logic signed [CW-1:0]      lx_q, ly_q, lz_q;
  logic [3*CW-1:0]           aim_q;
  logic                      mode_q;
  logic signed [15:0]        ci_q, co_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      lx_q   <= '0;
      ly_q   <= '0;
      lz_q   <= '0;
      aim_q  <= '0;
      mode_q <= 1'b0;
      ci_q   <= slr_pkg::COS_ONE;
      co_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        slr_pkg::CFG_RADIANCE:   rad_q  <= cfg_data_i[3*COLOR_WIDTH-1:0];
        slr_pkg::CFG_LIGHT_X:    lx_q   <= cfg_data_i[CW-1:0];
        slr_pkg::CFG_LIGHT_Y:    ly_q   <= cfg_data_i[CW-1:0];
        slr_pkg::CFG_LIGHT_Z:    lz_q   <= cfg_data_i[CW-1:0];
        slr_pkg::CFG_AIM_VECTOR: aim_q  <= cfg_data_i[3*CW-1:0];
        slr_pkg::CFG_AIM_MODE:   mode_q <= cfg_data_i[0];
        slr_pkg::CFG_COS_INNER:  ci_q   <= cfg_data_i[15:0];
        slr_pkg::CFG_COS_OUTER:  co_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic signed [CW-1:0] hit_w [3];
  logic signed [CW-1:0] lp_w  [3];
  assign hit_w[0] = hit_x_i;
  assign hit_w[1] = hit_y_i;
  assign hit_w[2] = hit_z_i;
  assign lp_w[0]  = lx_q;
  assign lp_w[1]  = ly_q;
  assign lp_w[2]  = lz_q;

  // ---------------------------------------------------------------- S1: offsets
  logic                 v1_q;
  logic signed [AW-1:0] d1_q [3];
  logic signed [AW-1:0] a1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_s1
    logic signed [CW-1:0] aim_c;
    assign aim_c = $signed(aim_q[i*CW +: CW]);
    always_ff @(posedge clk_i) begin
      d1_q[i] <= AW'(hit_w[i]) - AW'(lp_w[i]);
      a1_q[i] <= mode_q ? (AW'(aim_c) - AW'(lp_w[i])) : AW'(aim_c);
    end
  end

  // ---------------------------------------------------------------- S2: magnitudes
  logic [AW-1:0] dmag_c [3];
  logic [AW-1:0] amag_c [3];
  logic [AW-1:0] aor_c;
  logic [5:0]    sh_d;
  logic          far_d;

  always_comb begin
    far_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dmag_c[i] = d1_q[i][AW-1] ? AW'(-d1_q[i]) : AW'(d1_q[i]);
      amag_c[i] = a1_q[i][AW-1] ? AW'(-a1_q[i]) : AW'(a1_q[i]);
      far_d     = far_d | ((dmag_c[i] >> slr_pkg::DMAG_W) != '0);
    end
    aor_c = amag_c[0] | amag_c[1] | amag_c[2];
  end

  // halvings that bring the axis below 2^21
  always_comb begin
    sh_d = '0;
    for (int k = int'(slr_pkg::AMAG_W); k < int'(AW); k++) begin
      if (aor_c[k]) sh_d = 6'(k - int'(slr_pkg::AMAG_W) + 1);
    end
  end

  logic                           v2_q, dead2_q;
  logic [slr_pkg::DMAG_W-1:0]     dmag2_q [3];
  logic [slr_pkg::AMAG_W-1:0]     amag2_q [3];
  logic [2:0]                     dsgn2_q, asgn2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dead2_q <= far_d;
    for (int i = 0; i < 3; i++) begin
      dmag2_q[i] <= slr_pkg::DMAG_W'(dmag_c[i]);
      amag2_q[i] <= slr_pkg::AMAG_W'(amag_c[i] >> sh_d);
      dsgn2_q[i] <= d1_q[i][AW-1];
      asgn2_q[i] <= a1_q[i][AW-1];
    end
  end

  // ---------------------------------------------------------------- S3: squares
  logic                           v3_q, dead3_q;
  logic [2*slr_pkg::DMAG_W-1:0]   dsq3_q [3];
  logic [2*slr_pkg::AMAG_W-1:0]   asq3_q [3];
  logic [slr_pkg::DMAG_W-1:0]     dmag3_q [3];
  logic [slr_pkg::AMAG_W-1:0]     amag3_q [3];
  logic [2:0]                     dsgn3_q, asgn3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dead3_q <= dead2_q;
    dsgn3_q <= dsgn2_q;
    asgn3_q <= asgn2_q;
    for (int i = 0; i < 3; i++) begin
      dsq3_q[i]  <= dmag2_q[i] * dmag2_q[i];
      asq3_q[i]  <= amag2_q[i] * amag2_q[i];
      dmag3_q[i] <= dmag2_q[i];
      amag3_q[i] <= amag2_q[i];
    end
  end

  // ---------------------------------------------------------------- S4: norms
  logic [slr_pkg::DIST_W-1:0] dist2_d;
  logic [slr_pkg::ASUM_W-1:0] asum_d;
  assign dist2_d = slr_pkg::DIST_W'(dsq3_q[0]) + slr_pkg::DIST_W'(dsq3_q[1])
                 + slr_pkg::DIST_W'(dsq3_q[2]);
  assign asum_d  = slr_pkg::ASUM_W'(asq3_q[0]) + slr_pkg::ASUM_W'(asq3_q[1])
                 + slr_pkg::ASUM_W'(asq3_q[2]);

  logic                       v4_q;
  logic [slr_pkg::ASUM_W-1:0] asum4_q;
  slr_pkg::norm_side_t        side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    asum4_q       <= asum_d;
    side4_q.dead  <= dead3_q || (dist2_d == '0) || (asum_d == '0);
    side4_q.dist2 <= dist2_d;
    side4_q.dsgn  <= dsgn3_q;
    side4_q.asgn  <= asgn3_q;
    for (int i = 0; i < 3; i++) begin
      side4_q.dmag[i] <= dmag3_q[i];
      side4_q.amag[i] <= amag3_q[i];
    end
  end

  // ---------------------------------------------------------------- square roots
  logic                      sq_vld;
  logic [slr_pkg::LEN_W-1:0] len_d, len_a;
  slr_pkg::norm_side_t       nside;

  slr_isqrt #(
    .IN_W   (slr_pkg::SQRT_IN_W),
    .SIDE_W ($bits(slr_pkg::norm_side_t))
  ) u_sqrt_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .arg_i   (slr_pkg::SQRT_IN_W'({side4_q.dist2, 16'b0})),
    .side_i  (side4_q),
    .valid_o (sq_vld),
    .root_o  (len_d),
    .side_o  (nside)
  );

  slr_isqrt #(
    .IN_W   (slr_pkg::SQRT_IN_W),
    .SIDE_W (1)
  ) u_sqrt_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .arg_i   (slr_pkg::SQRT_IN_W'({asum4_q, 16'b0})),
    .side_i  (1'b0),
    .valid_o (),
    .root_o  (len_a),
    .side_o  ()
  );

  // ---------------------------------------------------------------- unit vectors
  logic                        dir_vld_w  [3];
  slr_pkg::dir_side_t          dir_side_w [3];
  slr_pkg::dir_side_t          dir_side_in;
  logic [slr_pkg::DIR_Q_W-1:0] dq_w [3];
  logic [slr_pkg::DIR_Q_W-1:0] aq_w [3];

  assign dir_side_in.dead  = nside.dead;
  assign dir_side_in.dist2 = nside.dist2;
  assign dir_side_in.dsgn  = nside.dsgn;
  assign dir_side_in.asgn  = nside.asgn;

  for (genvar i = 0; i < 3; i++) begin : g_dir
    slr_div #(
      .DEN_W  (slr_pkg::LEN_W),
      .Q_W    (slr_pkg::DIR_Q_W),
      .SIDE_W ($bits(slr_pkg::dir_side_t))
    ) u_div_d (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_vld),
      .num_i   (DIR_N_W'({nside.dmag[i], {slr_pkg::DIR_SHIFT{1'b0}}})),
      .den_i   (len_d),
      .side_i  (dir_side_in),
      .valid_o (dir_vld_w[i]),
      .quo_o   (dq_w[i]),
      .side_o  (dir_side_w[i])
    );

    slr_div #(
      .DEN_W  (slr_pkg::LEN_W),
      .Q_W    (slr_pkg::DIR_Q_W),
      .SIDE_W (1)
    ) u_div_a (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_vld),
      .num_i   (DIR_N_W'({nside.amag[i], {slr_pkg::DIR_SHIFT{1'b0}}})),
      .den_i   (len_a),
      .side_i  (1'b0),
      .valid_o (),
      .quo_o   (aq_w[i]),
      .side_o  ()
    );
  end

  // ---------------------------------------------------------------- P1: dot products
  logic signed [15:0] ud_c [3];
  logic signed [15:0] ua_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [14:0] md, ma;
      md = (dq_w[i] > slr_pkg::ONE_Q14) ? slr_pkg::ONE_Q14 : dq_w[i];
      ma = (aq_w[i] > slr_pkg::ONE_Q14) ? slr_pkg::ONE_Q14 : aq_w[i];
      ud_c[i] = dir_side_w[0].dsgn[i] ? -$signed({1'b0, md}) : $signed({1'b0, md});
      ua_c[i] = dir_side_w[0].asgn[i] ? -$signed({1'b0, ma}) : $signed({1'b0, ma});
    end
  end

  logic                       p1_v_q, p1_dead_q;
  logic [slr_pkg::DIST_W-1:0] p1_dist2_q;
  logic signed [31:0]         p1_prod_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else begin
      p1_v_q <= dir_vld_w[0];
    end
  end

  always_ff @(posedge clk_i) begin
    p1_dead_q  <= dir_side_w[0].dead;
    p1_dist2_q <= dir_side_w[0].dist2;
    for (int i = 0; i < 3; i++) begin
      p1_prod_q[i] <= ud_c[i] * ua_c[i];
    end
  end

  // ---------------------------------------------------------------- P2: cosine
  logic signed [32:0] dot_c;
  logic [32:0]        dmag_dot_c, rnd_c;
  logic [14:0]        csmag_c;
  logic signed [15:0] cs_d;

  always_comb begin
    dot_c      = 33'(p1_prod_q[0]) + 33'(p1_prod_q[1]) + 33'(p1_prod_q[2]);
    dmag_dot_c = dot_c[32] ? 33'(-dot_c) : 33'(dot_c);
    rnd_c      = (dmag_dot_c + 33'd8192) >> slr_pkg::T_Q_W;
    csmag_c    = (rnd_c > 33'(slr_pkg::ONE_Q14)) ? slr_pkg::ONE_Q14 : rnd_c[14:0];
    cs_d       = dot_c[32] ? -$signed({1'b0, csmag_c}) : $signed({1'b0, csmag_c});
  end

  logic                       p2_v_q, p2_dead_q;
  logic [slr_pkg::DIST_W-1:0] p2_dist2_q;
  logic signed [15:0]         p2_cs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_dead_q  <= p1_dead_q;
    p2_dist2_q <= p1_dist2_q;
    p2_cs_q    <= cs_d;
  end

  // ---------------------------------------------------------------- P3: cone terms
  logic signed [17:0] num_c;
  logic signed [16:0] den17_c;
  logic [15:0]        den_c;
  logic               cone_dead_c, sat_t_c;

  always_comb begin
    num_c       = 18'(p2_cs_q) - 18'(co_q);
    den17_c     = 17'(ci_q) - 17'(co_q);
    den_c       = (den17_c < 17'sd16) ? slr_pkg::DEN_MIN : den17_c[15:0];
    cone_dead_c = num_c[17] || (num_c == '0);
    sat_t_c     = !cone_dead_c && (num_c[15:0] >= den_c);
  end

  logic                v5_q;
  logic [15:0]         tnum_q, tden_q;
  slr_pkg::cone_side_t cside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tnum_q        <= (cone_dead_c || sat_t_c) ? 16'd0 : num_c[15:0];
    tden_q        <= den_c;
    cside_q.dead  <= p2_dead_q || cone_dead_c;
    cside_q.sat_t <= sat_t_c;
    cside_q.dist2 <= p2_dist2_q;
  end

  // ---------------------------------------------------------------- cone divider
  logic                      t_vld;
  logic [slr_pkg::T_Q_W-1:0] t_quo;
  slr_pkg::cone_side_t       tside;

  slr_div #(
    .DEN_W  (16),
    .Q_W    (slr_pkg::T_Q_W),
    .SIDE_W ($bits(slr_pkg::cone_side_t))
  ) u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .num_i   ({tnum_q, {slr_pkg::T_Q_W{1'b0}}}),
    .den_i   (tden_q),
    .side_i  (cside_q),
    .valid_o (t_vld),
    .quo_o   (t_quo),
    .side_o  (tside)
  );

  // ---------------------------------------------------------------- T: t squared
  logic [14:0] t_c;
  assign t_c = tside.sat_t ? slr_pkg::ONE_Q14 : {1'b0, t_quo};

  logic                       v6_q, dead6_q;
  logic [29:0]                tsq6_q;
  logic [slr_pkg::DIST_W-1:0] dist6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= t_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tsq6_q  <= t_c * t_c;
    dead6_q <= tside.dead;
    dist6_q <= tside.dist2;
  end

  // ---------------------------------------------------------------- ANG: cone factor
  logic [14:0] ang_c;
  assign ang_c = 15'((tsq6_q + 30'd8192) >> slr_pkg::T_Q_W);

  logic                       v7_q, dead7_q;
  logic [14:0]                ang7_q;
  logic [slr_pkg::DIST_W-1:0] dd7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ang7_q  <= ang_c;
    dead7_q <= dead6_q || (ang_c == '0);
    dd7_q   <= (dist6_q < slr_pkg::DIST_MIN) ? slr_pkg::DIST_MIN : dist6_q;
  end

  // ---------------------------------------------------------------- PROD: color scale
  logic                           v8_q, dead8_q;
  logic [COLOR_WIDTH+14:0]        cprod8_q [3];
  logic [slr_pkg::DIST_W-1:0]     dd8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else begin
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dead8_q <= dead7_q;
    dd8_q   <= dd7_q;
    for (int i = 0; i < 3; i++) begin
      cprod8_q[i] <= rad_q[i*COLOR_WIDTH +: COLOR_WIDTH] * ang7_q;
    end
  end

  // ---------------------------------------------------------------- NUMER: clip test
  logic [CDIV_W-1:0]  lim_c;
  logic [NUMER_W-1:0] numer_c [3];
  logic [2:0]         csat_c;

  always_comb begin
    lim_c = {dd8_q, {COLOR_WIDTH{1'b0}}};
    for (int i = 0; i < 3; i++) begin
      numer_c[i] = {cprod8_q[i], 2'b00};
      csat_c[i]  = CDIV_W'(numer_c[i]) >= lim_c;
    end
  end

  logic                       v9_q;
  logic [CDIV_W-1:0]          cnum9_q [3];
  logic [slr_pkg::DIST_W-1:0] dd9_q;
  slr_pkg::col_side_t         kside9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q <= 1'b0;
    end else begin
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dd9_q         <= dd8_q;
    kside9_q.dead <= dead8_q;
    kside9_q.sat  <= csat_c;
    for (int i = 0; i < 3; i++) begin
      cnum9_q[i] <= csat_c[i] ? '0 : CDIV_W'(numer_c[i]);
    end
  end

  // ---------------------------------------------------------------- color dividers
  logic                   col_vld_w  [3];
  slr_pkg::col_side_t     col_side_w [3];
  logic [COLOR_WIDTH-1:0] col_q_w    [3];

  for (genvar i = 0; i < 3; i++) begin : g_col
    slr_div #(
      .DEN_W  (slr_pkg::DIST_W),
      .Q_W    (COLOR_WIDTH),
      .SIDE_W ($bits(slr_pkg::col_side_t))
    ) u_div_c (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v9_q),
      .num_i   (cnum9_q[i]),
      .den_i   (dd9_q),
      .side_i  (kside9_q),
      .valid_o (col_vld_w[i]),
      .quo_o   (col_q_w[i]),
      .side_o  (col_side_w[i])
    );
  end

  // ---------------------------------------------------------------- output beat
  logic                   done_q, sat_q;
  logic [COLOR_WIDTH-1:0] comp_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= col_vld_w[0];
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= !col_side_w[0].dead && (col_side_w[0].sat != 3'b000);
    for (int i = 0; i < 3; i++) begin
      if (col_side_w[0].dead) begin
        comp_q[i] <= '0;
      end else if (col_side_w[0].sat[i]) begin
        comp_q[i] <= '1;
      end else begin
        comp_q[i] <= col_q_w[i];
      end
    end
  end

  assign done_o      = done_q;
  assign red_o       = comp_q[0];
  assign green_o     = comp_q[1];
  assign blue_o      = comp_q[2];
  assign saturated_o = sat_q;

  // ---------------------------------------------------------------- checks
  // a clipped beat carries at least one full-scale component
  a_sat_has_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturated_o |-> (red_o == '1) || (green_o == '1) || (blue_o == '1))
    else $error("saturated beat without a full-scale component");

  // x component of the hit direction of a live hit never exceeds one in Q1.14
  a_dir_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_vld_w[0] && !dir_side_w[0].dead |-> dq_w[0] <= 15'(slr_pkg::ONE_Q14))
    else $error("direction component above one");

  // cone divider only sees numerators below the divisor
  a_cone_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> tnum_q < tden_q || tnum_q == '0)
    else $error("cone divider operand out of range");

endmodule

/* verif/tb_spot_light_radiance.sv */
`timescale 1ns / 1ps
// tb_spot_light_radiance: self-checking bench for the spot light radiance pipeline.
// Drives directed and random hit beats in bursts, predicts untyped radiances in SV and checks done_o beats.
// Depends on rtl/slr_pkg.sv and rtl/spot_light_radiance.sv.
module tb_spot_light_radiance;

  localparam int unsigned CW       = 20;
  localparam int unsigned KW       = 16;
  localparam int unsigned DW       = 60;
  localparam int          LATENCY  = 50;
  localparam int          N_PHASES = 11;
  localparam int          PER_PH   = 150;
  localparam longint      LIMIT    = 400000;

  typedef struct packed {
    logic [KW-1:0] red;
    logic [KW-1:0] green;
    logic [KW-1:0] blue;
    logic          sat;
  } radiance_t;

  typedef struct {
    int        hx;
    int        hy;
    int        hz;
    bit        typed;
    radiance_t exp;
  } hit_row_t;

  logic          clk_i     = 1'b0;
  logic          rst_ni    = 1'b0;
  logic          cfg_we_i  = 1'b0;
  logic [2:0]    cfg_idx_i = '0;
  logic [DW-1:0] cfg_data_i = '0;
  logic          start     = 1'b0;
  logic          busy;
  logic signed [CW-1:0] hit_x_i = '0, hit_y_i = '0, hit_z_i = '0;
  logic          done_o;
  logic [KW-1:0] red_o, green_o, blue_o;
  logic          saturated_o;

  spot_light_radiance dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start, .busy,
    .hit_x_i, .hit_y_i, .hit_z_i, .done_o, .red_o, .green_o, .blue_o, .saturated_o
  );

  always #2 clk_i = ~clk_i;

  // shadow copy of the light registers
  logic [3*KW-1:0] sh_rad;
  logic [CW-1:0]   sh_lx, sh_ly, sh_lz;
  logic [3*CW-1:0] sh_aim;
  logic            sh_mode;
  logic [15:0]     sh_ci, sh_co;

  radiance_t pending_q[$];
  int        errs = 0;
  longint    cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errs++;
  endtask

  function automatic longint sx(input logic [CW-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit vector in Q1.14; returns 0 for a zero vector
  function automatic bit unit_dir(input longint v[3], output longint u[3]);
    longint unsigned n, len;
    longint c;
    n = 0;
    for (int i = 0; i < 3; i++) n += longint'(v[i] * v[i]);
    if (n == 0) return 1'b0;
    len = int_sqrt(n << 16);
    for (int i = 0; i < 3; i++) begin
      c = (v[i] * 64'sd4194304) / longint'(len);
      if (c > 16384) c = 16384;
      if (c < -16384) c = -16384;
      u[i] = c;
    end
    return 1'b1;
  endfunction

  function automatic radiance_t predict_radiance(input logic [CW-1:0] hx, hy, hz);
    longint lp[3], d[3], a[3], ud[3], ua[3], hv[3];
    longint dot, cs, ci, co, den, num, t, ang;
    longint unsigned dist2, c, v;
    bit ok;
    radiance_t r;
    r = '0;
    ok = 1'b1;
    lp[0] = sx(sh_lx); lp[1] = sx(sh_ly); lp[2] = sx(sh_lz);
    hv[0] = sx(hx);    hv[1] = sx(hy);    hv[2] = sx(hz);
    for (int i = 0; i < 3; i++) begin
      d[i] = hv[i] - lp[i];
      if (d[i] >= (64'sd1 << 20) || d[i] <= -(64'sd1 << 20)) ok = 1'b0;
      a[i] = sx(sh_aim[i*CW +: CW]);
      if (sh_mode) a[i] -= lp[i];
    end
    if (!ok) return r;
    dist2 = 0;
    for (int i = 0; i < 3; i++) dist2 += longint'(d[i] * d[i]);
    if (dist2 == 0) return r;
    // shrink an oversized axis before normalizing
    while (a[0] >= 2**21 || a[0] <= -(2**21) || a[1] >= 2**21 || a[1] <= -(2**21) ||
           a[2] >= 2**21 || a[2] <= -(2**21)) begin
      for (int i = 0; i < 3; i++) a[i] = a[i] / 2;
    end
    if (!unit_dir(a, ua)) return r;
    if (!unit_dir(d, ud)) return r;
    dot = ua[0] * ud[0] + ua[1] * ud[1] + ua[2] * ud[2];
    cs = (dot >= 0) ? ((dot + 8192) >>> 14) : -((-dot + 8192) >>> 14);
    if (cs > 16384) cs = 16384;
    if (cs < -16384) cs = -16384;
    ci = longint'($signed(sh_ci));
    co = longint'($signed(sh_co));
    den = ci - co;
    if (den < 16) den = 16;
    num = cs - co;
    if (num <= 0) return r;
    t = (num * 16384) / den;
    if (t > 16384) t = 16384;
    ang = (t * t + 8192) >>> 14;
    if (ang == 0) return r;
    if (dist2 < 7) dist2 = 7;
    for (int i = 0; i < 3; i++) begin
      c = sh_rad[i*KW +: KW];
      v = (c * longint'(ang) * 4) / dist2;
      if (v > 65535) begin
        v = 65535;
        r.sat = 1'b1;
      end
      if (i == 0) r.red = v[KW-1:0];
      else if (i == 1) r.green = v[KW-1:0];
      else r.blue = v[KW-1:0];
    end
    return r;
  endfunction

  // result checker: one beat per done_o
  always @(posedge clk_i) begin
    radiance_t got, want;
    if (rst_ni && done_o) begin
      got = '{red: red_o, green: green_o, blue: blue_o, sat: saturated_o};
      if (pending_q.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        want = pending_q.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.sat !== want.sat)
          report_mismatch($sformatf("got %h/%h/%h s%b want %h/%h/%h s%b",
            got.red, got.green, got.blue, got.sat,
            want.red, want.green, want.blue, want.sat));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL spot_light_radiance");
      $finish;
    end
  end

  // register write; we stays high across back-to-back writes
  task automatic write_reg(input slr_pkg::cfg_idx_e idx, input logic [DW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      slr_pkg::CFG_RADIANCE:   sh_rad  = data[3*KW-1:0];
      slr_pkg::CFG_LIGHT_X:    sh_lx   = data[CW-1:0];
      slr_pkg::CFG_LIGHT_Y:    sh_ly   = data[CW-1:0];
      slr_pkg::CFG_LIGHT_Z:    sh_lz   = data[CW-1:0];
      slr_pkg::CFG_AIM_VECTOR: sh_aim  = data[3*CW-1:0];
      slr_pkg::CFG_AIM_MODE:   sh_mode = data[0];
      slr_pkg::CFG_COS_INNER:  sh_ci   = data[15:0];
      slr_pkg::CFG_COS_OUTER:  sh_co   = data[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [DW-1:0] junk60();
    return DW'({$urandom, $urandom});
  endfunction

  // one hit beat; start is left high for a following beat
  task automatic send_hit(input logic [CW-1:0] x, y, z, input bit typed,
                          input radiance_t exp);
    hit_x_i <= x;
    hit_y_i <= y;
    hit_z_i <= z;
    start   <= 1'b1;
    do @(posedge clk_i); while (busy);
    pending_q.push_back(typed ? exp : predict_radiance(x, y, z));
  endtask

  task automatic idle_for(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // wait out every pending result plus pipeline depth
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [CW-1:0] pick_coord(input int p);
    case ($urandom_range(0, 5))
      0:       return (p % 2) ? 20'h7FFFF : 20'h80000;
      1:       return CW'($urandom);
      default: return CW'($signed($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  task automatic pick_setting(input int p);
    logic [DW-1:0] w;
    logic [15:0] co, ci;
    int sel;
    // radiance
    w = junk60();
    if (p == 1) w[47:0] = '0;
    else if (p == 2 || $urandom_range(0, 3) == 0) w[47:0] = '1;
    else if ($urandom_range(0, 1)) w[47:0] = {3{4'h0, 12'($urandom)}};
    write_reg(slr_pkg::CFG_RADIANCE, w);
    w = junk60(); w[CW-1:0] = (p == 1) ? 20'h80000 : (p == 2) ? 20'h7FFFF : pick_coord(p);
    write_reg(slr_pkg::CFG_LIGHT_X, w);
    w = junk60(); w[CW-1:0] = (p == 1) ? 20'h80000 : (p == 2) ? 20'h7FFFF : pick_coord(p);
    write_reg(slr_pkg::CFG_LIGHT_Y, w);
    w = junk60(); w[CW-1:0] = (p == 1) ? 20'h80000 : (p == 2) ? 20'h7FFFF : pick_coord(p);
    write_reg(slr_pkg::CFG_LIGHT_Z, w);
    w = junk60();
    for (int i = 0; i < 3; i++)
      if (p > 2 && $urandom_range(0, 2) != 0) w[i*CW +: CW] = pick_coord(p + i);
    if (p == 1) w[3*CW-1:0] = {3{20'h80000}};
    if (p == 2) w[3*CW-1:0] = {3{20'h7FFFF}};
    write_reg(slr_pkg::CFG_AIM_VECTOR, w);
    w = junk60(); w[0] = (p % 2 == 1);
    write_reg(slr_pkg::CFG_AIM_MODE, w);
    sel = $urandom_range(0, 5);
    co = 16'($signed($urandom_range(0, 32768)) - 16384);
    ci = co + 16'($urandom_range(0, 8000));
    if (sel == 0) begin ci = 16'($urandom); co = 16'($urandom); end
    else if (sel == 1) begin ci = co - 16'($urandom_range(0, 40)); end
    if (p == 1) begin ci = 16'h8000; co = 16'hC000; end
    if (p == 2) begin ci = 16'sd16384; co = -16'sd16384; end
    w = junk60(); w[15:0] = ci;
    write_reg(slr_pkg::CFG_COS_INNER, w);
    w = junk60(); w[15:0] = co;
    write_reg(slr_pkg::CFG_COS_OUTER, w);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // hit near the light, biased along the cone axis, or at times a fully random hit
  task automatic random_hit(output logic [CW-1:0] x, y, z);
    longint a[3], o[3];
    longint mx;
    int sh, m;
    if ($urandom_range(0, 4) == 0) begin
      x = CW'($urandom); y = CW'($urandom); z = CW'($urandom);
      return;
    end
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = sx(sh_aim[i*CW +: CW]);
      if (sh_mode) a[i] -= (i == 0) ? sx(sh_lx) : (i == 1) ? sx(sh_ly) : sx(sh_lz);
      if (a[i] > mx) mx = a[i];
      if (-a[i] > mx) mx = -a[i];
    end
    m = $urandom_range(2, 14);
    sh = 0;
    while ((mx >>> sh) >= (64'sd1 << m)) sh++;
    for (int i = 0; i < 3; i++) begin
      o[i] = ($urandom_range(0, 3) != 0) ? (a[i] >>> sh) : 0;
      o[i] += longint'($urandom_range(0, 2 << (m / 2))) - (1 << (m / 2));
    end
    x = CW'(sx(sh_lx) + o[0]);
    y = CW'(sx(sh_ly) + o[1]);
    z = CW'(sx(sh_lz) + o[2]);
  endtask

  initial begin
    hit_row_t rst_rows[$];
    hit_row_t cone_rows[$];
    radiance_t zero_r, full_r, clip_r;
    logic [CW-1:0] x, y, z;
    int burst;
    zero_r = '0;
    full_r = '{red: 16'hFFFF, green: 16'hFFFF, blue: 16'hFFFF, sat: 1'b0};
    clip_r = '{red: 16'hFFFF, green: 16'hFFFF, blue: 16'hFFFF, sat: 1'b1};
    sh_rad = '0; sh_lx = '0; sh_ly = '0; sh_lz = '0; sh_aim = '0; sh_mode = 1'b0;
    sh_ci = 16'sd16384; sh_co = '0;

    // reset defaults: zero axis and zero radiance, every hit gives zero
    rst_rows = '{
      '{0, 0, 0, 1, zero_r}, '{524287, 524287, 524287, 1, zero_r},
      '{-524288, -524288, -524288, 1, zero_r}, '{0, 0, 256, 1, zero_r},
      '{1, -1, 1, 1, zero_r}};
    // axis +z, full color, inner cos 1, outer cos 0
    cone_rows = '{
      '{0, 0, 0, 1, zero_r},            // hit exactly at the light
      '{0, 0, 256, 1, full_r},          // on axis at unit distance
      '{0, 0, 1, 1, clip_r},            // distance clamp, clipped
      '{0, 0, -256, 1, zero_r},         // behind the light
      '{256, 0, 0, 1, zero_r},          // at the outer edge
      '{0, 0, 524287, 0, zero_r},
      '{0, 0, -524288, 0, zero_r},
      '{524287, 524287, 524287, 0, zero_r},
      '{-524288, 0, 524287, 0, zero_r},
      '{100, 50, 300, 0, zero_r},
      '{-37, 12, 900, 0, zero_r},
      '{3, 3, 3, 0, zero_r},
      '{-200, -100, 180, 0, zero_r},
      '{10, 0, 4000, 0, zero_r}};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (rst_rows[i])
      send_hit(CW'(rst_rows[i].hx), CW'(rst_rows[i].hy), CW'(rst_rows[i].hz),
               rst_rows[i].typed, rst_rows[i].exp);
    drain();

    write_reg(slr_pkg::CFG_RADIANCE, {12'h0, 48'hFFFF_FFFF_FFFF});
    write_reg(slr_pkg::CFG_AIM_VECTOR, {20'd256, 20'd0, 20'd0});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    foreach (cone_rows[i]) begin
      send_hit(CW'(cone_rows[i].hx), CW'(cone_rows[i].hy), CW'(cone_rows[i].hz),
               cone_rows[i].typed, cone_rows[i].exp);
      if (i % 4 == 3) idle_for($urandom_range(1, 3));
    end
    drain();

    // random phases, each under its own light setting
    for (int p = 0; p < N_PHASES; p++) begin
      pick_setting(p);
      burst = $urandom_range(1, 30);
      for (int n = 0; n < PER_PH; n++) begin
        random_hit(x, y, z);
        send_hit(x, y, z, 1'b0, zero_r);
        if (--burst == 0) begin
          // some phases run flat out, others idle between bursts
          if (p % 3 != 0) idle_for($urandom_range(1, 8));
          burst = $urandom_range(1, 30);
        end
      end
      drain();
    end

    if (errs == 0) $display("PASS spot_light_radiance");
    else $display("FAIL spot_light_radiance");
    $finish;
  end
endmodule
